// File: src/mrs_pkg.sv
// Shared types, constants and helper functions of the motion report scheduler.
package mrs_pkg;

    typedef enum logic [1:0] {
        MODE_MOTION  = 2'd0,
        MODE_OUTCOME = 2'd1,
        MODE_RECONF  = 2'd2,
        MODE_QUERY   = 2'd3
    } mode_e;

    typedef enum logic [1:0] {
        CFG_MOVING = 2'd0,
        CFG_IDLE   = 2'd1,
        CFG_QUIET  = 2'd2
    } cfg_idx_e;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    localparam logic [15:0] MOVING_MIN   = 16'd1000;
    localparam logic [15:0] MOVING_MAX   = 16'd60000;
    localparam logic [21:0] IDLE_MIN     = 22'd60000;
    localparam logic [21:0] IDLE_MAX     = 22'd3600000;
    localparam logic [18:0] QUIET_MIN    = 19'd5000;
    localparam logic [18:0] QUIET_MAX    = 19'd300000;
    localparam logic [15:0] MOVING_RESET = 16'd5000;
    localparam logic [21:0] IDLE_RESET   = 22'd600000;
    localparam logic [18:0] QUIET_RESET  = 19'd30000;
    localparam logic [21:0] RETRY_GAP_MS = 22'd5000;
    localparam logic [1:0]  MAX_RETRIES  = 2'd2;

    typedef struct packed {
        mode_e       mode;
        logic [63:0] now_ms;
        logic        motion;
        logic        sent;
    } in_t;

    typedef struct packed {
        logic        due;
        logic        is_moving;
        logic [31:0] wakes;
        logic        accepted;
        logic [1:0]  retries;
    } out_t;

    typedef struct packed {
        logic [15:0] moving_period;
        logic [21:0] idle_ms;
        logic [18:0] quiet_period;
    } timing_t;

    typedef struct packed {
        mode_e       op;
        logic [63:0] now_ms;
        logic        motion;
        logic        sent;
        logic        cfg_ok;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // Adds a duration to a time, saturating at the all-ones time.
    function automatic logic [63:0] sat_add(input logic [63:0] t, input logic [21:0] d);
        logic [64:0] sum;
        sum = {1'b0, t} + {43'd0, d};
        return sum[64] ? {64{1'b1}} : sum[63:0];
    endfunction

endpackage

// File: src/mrs_front.sv
// Front end: configuration registers, timing validity check and command decode.
module mrs_front
    import mrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  in_t                   in_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  fifo_status_t          cmd_status,
    output logic                  full,
    output logic                  cmd_wr,
    output cmd_t                  cmd,
    output timing_t               timing
);

    logic [15:0] moving_reg, moving_next;
    logic [21:0] idle_reg,   idle_next;
    logic [18:0] quiet_reg,  quiet_next;
    logic        cfg_ok;

    always_comb
    begin
        moving_next = moving_reg;
        idle_next   = idle_reg;
        quiet_next  = quiet_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOVING: moving_next = cfg_data[15:0];
                CFG_IDLE:   idle_next   = cfg_data[21:0];
                CFG_QUIET:  quiet_next  = cfg_data[18:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moving_reg <= MOVING_RESET;
            idle_reg   <= IDLE_RESET;
            quiet_reg  <= QUIET_RESET;
        end
        else
        begin
            moving_reg <= moving_next;
            idle_reg   <= idle_next;
            quiet_reg  <= quiet_next;
        end
    end

    // The registers must change only while the block is idle; the block itself does not
    // enforce this, so the check is evaluated here and carried with each command.
    always_comb
    begin
        cfg_ok = (moving_reg inside {[MOVING_MIN:MOVING_MAX]}) &&
                 (idle_reg inside {[IDLE_MIN:IDLE_MAX]}) &&
                 (quiet_reg inside {[QUIET_MIN:QUIET_MAX]}) &&
                 (idle_reg >= {6'd0, moving_reg});
    end

    assign full   = cmd_status.full;
    assign cmd_wr = push && !cmd_status.full;

    always_comb
    begin
        cmd.op     = in_data.mode;
        cmd.now_ms = in_data.now_ms;
        cmd.motion = in_data.motion && (in_data.mode == MODE_MOTION);
        cmd.sent   = in_data.sent && (in_data.mode == MODE_OUTCOME);
        cmd.cfg_ok = cfg_ok && (in_data.mode == MODE_RECONF);
    end

    assign timing.moving_period = moving_reg;
    assign timing.idle_ms       = idle_reg;
    assign timing.quiet_period  = quiet_reg;

endmodule

// File: src/mrs_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
module mrs_cmd_fifo
    import mrs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  cmd_t         wr_cmd,
    input  logic         rd_en,
    output cmd_t         rd_cmd,
    output fifo_status_t status
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_wr, do_rd;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: src/mrs_back.sv
// Back end: scheduler state update, due evaluation and the result queue.
module mrs_back
    import mrs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  fifo_status_t cmd_status,
    input  cmd_t         cmd,
    input  timing_t      timing,
    input  logic         pop,
    output logic         cmd_rd,
    output logic         empty,
    output out_t         out_data
);

    logic [63:0] last_time_reg, last_time_next;
    logic        moving_reg,    moving_next;
    logic [31:0] wake_reg,      wake_next;
    logic [63:0] next_rep_reg,  next_rep_next;
    logic [63:0] quiet_dl_reg,  quiet_dl_next;
    logic        pending_reg,   pending_next;
    logic [1:0]  retry_reg,     retry_next;
    timing_t     active_reg,    active_next;

    out_t        res_q_reg [2];
    logic        res_wr_ptr_reg, res_rd_ptr_reg;
    logic [1:0]  res_count_reg;

    logic [63:0] t;
    logic        t_max;
    logic        ge_next, ge_quiet;
    logic        next_upd, quiet_upd;
    logic        accepted;
    out_t        result;
    logic        res_pop, res_room, step;

    assign res_pop  = pop && (res_count_reg != 2'd0);
    assign res_room = (res_count_reg != 2'd2) || res_pop;
    assign step     = !cmd_status.empty && res_room;
    assign cmd_rd   = step;
    assign empty    = (res_count_reg == 2'd0);
    assign out_data = res_q_reg[res_rd_ptr_reg];

    // Time never runs backward.
    assign t        = (cmd.now_ms < last_time_reg) ? last_time_reg : cmd.now_ms;
    assign t_max    = &t;
    assign ge_next  = (t >= next_rep_reg);
    assign ge_quiet = (t >= quiet_dl_reg);

    always_comb
    begin
        last_time_next = last_time_reg;
        moving_next    = moving_reg;
        wake_next      = wake_reg;
        next_rep_next  = next_rep_reg;
        quiet_dl_next  = quiet_dl_reg;
        pending_next   = pending_reg;
        retry_next     = retry_reg;
        active_next    = active_reg;
        next_upd       = 1'b0;
        quiet_upd      = 1'b0;
        accepted       = 1'b0;
        case (cmd.op)
            MODE_MOTION:
            begin
                last_time_next = t;
                if (cmd.motion)
                begin
                    if (!moving_reg)
                    begin
                        moving_next  = 1'b1;
                        retry_next   = 2'd0;
                        pending_next = 1'b1;
                        if (wake_reg != {32{1'b1}})
                        begin
                            wake_next = wake_reg + 32'd1;
                        end
                    end
                    quiet_dl_next = sat_add(t, {3'd0, active_reg.quiet_period});
                    quiet_upd     = 1'b1;
                end
                else if (moving_reg && ge_quiet)
                begin
                    moving_next  = 1'b0;
                    pending_next = 1'b1;
                end
            end
            MODE_OUTCOME:
            begin
                last_time_next = t;
                pending_next   = 1'b0;
                next_upd       = 1'b1;
                if (cmd.sent || moving_reg || (retry_reg >= MAX_RETRIES))
                begin
                    retry_next    = 2'd0;
                    next_rep_next = sat_add(t, moving_reg ? {6'd0, active_reg.moving_period}
                                                          : active_reg.idle_ms);
                end
                else
                begin
                    retry_next    = retry_reg + 2'd1;
                    next_rep_next = sat_add(t, RETRY_GAP_MS);
                end
            end
            MODE_RECONF:
            begin
                if (cmd.cfg_ok)
                begin
                    last_time_next = t;
                    active_next    = timing;
                    retry_next     = 2'd0;
                    pending_next   = 1'b1;
                    accepted       = 1'b1;
                    if (moving_reg)
                    begin
                        quiet_dl_next = sat_add(t, {3'd0, timing.quiet_period});
                        quiet_upd     = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Every duration is nonzero, so a freshly computed deadline is reached
    // only when the time itself sits at the saturated value.
    always_comb
    begin
        result.due       = pending_next || (next_upd ? t_max : ge_next) ||
                           (moving_next && (quiet_upd ? t_max : ge_quiet));
        result.is_moving = moving_next;
        result.wakes     = wake_next;
        result.accepted  = accepted;
        result.retries   = retry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg      <= '0;
            moving_reg         <= 1'b0;
            wake_reg           <= '0;
            next_rep_reg       <= '0;
            quiet_dl_reg       <= '0;
            pending_reg        <= 1'b1;
            retry_reg          <= 2'd0;
            active_reg.moving_period <= MOVING_RESET;
            active_reg.idle_ms       <= IDLE_RESET;
            active_reg.quiet_period  <= QUIET_RESET;
        end
        else if (step)
        begin
            last_time_reg <= last_time_next;
            moving_reg    <= moving_next;
            wake_reg      <= wake_next;
            next_rep_reg  <= next_rep_next;
            quiet_dl_reg  <= quiet_dl_next;
            pending_reg   <= pending_next;
            retry_reg     <= retry_next;
            active_reg    <= active_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_count_reg  <= 2'd0;
        end
        else
        begin
            if (step)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            end
            res_count_reg <= res_count_reg + {1'b0, step} - {1'b0, res_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_q_reg[res_wr_ptr_reg] <= result;
        end
    end

endmodule

// File: src/motion_report_scheduler.sv
// Top level of the motion report scheduler.
// The scheduler takes one word per clock on its input queue interface (push while full is
// low) and returns exactly one result word per input word, in order, on its output queue
// interface (read while empty is low, pop to take). Each word carries a mode: a motion
// update, a send outcome, a reconfigure request or a due query, along with a millisecond
// timestamp that is clamped so it never runs backward. A word is decoded by the front end
// into a two-entry command queue; the back end then updates the scheduler state and places
// the result in a two-entry result queue, whose oldest entry drives the result ports.
// The sustained rate is one word per cycle while results are popped, set by the back
// end's state update, which must see the previous word's stored time; full rises only
// when both command entries wait because the result queue is full and not being popped.
// The timing registers (index 0 moving interval, 1 idle interval, 2 quiet time) are
// written through cfg_we, cfg_index and cfg_data; they take effect only when a reconfigure
// word finds them valid, and should be written only while no word is in flight. Writes to
// index 3 are ignored.
module motion_report_scheduler
    import mrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  in_t                   in_data,
    output logic                  empty,
    input  logic                  pop,
    output out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fifo_status_t cmd_status;
    logic         cmd_wr;
    logic         cmd_rd;
    cmd_t         cmd_in;
    cmd_t         cmd_out;
    timing_t      timing;

    // Front end: holds the timing registers and decodes each input word.
    mrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_data    (in_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_status (cmd_status),
        .full       (full),
        .cmd_wr     (cmd_wr),
        .cmd        (cmd_in),
        .timing     (timing)
    );

    // The command queue lets the front end accept up to two words while the back end stalls.
    mrs_cmd_fifo u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_wr),
        .wr_cmd (cmd_in),
        .rd_en  (cmd_rd),
        .rd_cmd (cmd_out),
        .status (cmd_status)
    );

    // Back end: applies each command to the scheduler state and queues the result.
    mrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_status (cmd_status),
        .cmd        (cmd_out),
        .timing     (timing),
        .pop        (pop),
        .cmd_rd     (cmd_rd),
        .empty      (empty),
        .out_data   (out_data)
    );

endmodule

// File: test/tb_motion_report_scheduler.sv
// Self-checking testbench for the motion report scheduler top level.
module tb_motion_report_scheduler;
    import mrs_pkg::*;

    // Timing limits of the scheduler, used both to decide whether a reconfigure word
    // is accepted and to build the extreme register settings of the stimulus.
    localparam int MOVING_LO = 1000;
    localparam int MOVING_HI = 60000;
    localparam int IDLE_LO = 60000;
    localparam int IDLE_HI = 3600000;
    localparam int QUIET_LO = 5000;
    localparam int QUIET_HI = 300000;
    localparam int RETRY_GAP = 5000;
    localparam int RETRY_LIMIT = 2;
    localparam logic [63:0] TIME_MAX = {64{1'b1}};
    // Register index 3 exists on the port but selects no register.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // The slowest correct run stays far below this limit.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int PHASES = 13;
    localparam int WORDS_PER_PHASE = 100;
    localparam int PRINT_CAP = 200;

    logic clk = 1'b0;
    logic rst_n;
    logic push;
    logic full;
    in_t in_data;
    logic empty;
    logic pop;
    out_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    motion_report_scheduler u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .in_data(in_data),
        .empty(empty),
        .pop(pop),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Words waiting to be offered to the block, and the result words predicted for the
    // words it has already taken, oldest first.
    in_t pending_words[$];
    out_t predicted_words[$];

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned words_checked = 0;
    logic word_taken = 1'b0;
    logic calm;

    // Time base of the stimulus; it only moves forward, backward words are derived from it.
    logic [63:0] clock_ms = 64'd0;

    // Register contents as last written through the configuration port.
    logic [15:0] reg_moving = 16'd5000;
    logic [21:0] reg_idle = 22'd600000;
    logic [18:0] reg_quiet = 19'd30000;

    // Scheduler state as the block should hold it after each word it has taken.
    logic [63:0] last_ms = 64'd0;
    logic moving = 1'b0;
    logic [31:0] wake_cnt = 32'd0;
    logic [63:0] next_due_ms = 64'd0;
    logic [63:0] quiet_until_ms = 64'd0;
    logic pending = 1'b1;
    logic [1:0] retry_cnt = 2'd0;
    logic [15:0] act_moving = 16'd5000;
    logic [21:0] act_idle = 22'd600000;
    logic [18:0] act_quiet = 19'd30000;

    // Both sides stop idling in calm windows that recur as the cycle count advances, so
    // back-to-back traffic in both directions is seen as well as the random gaps.
    assign calm = (cycle_count % 2000) < 400;

    // Adds a duration to a time; a sum past the largest time sticks at the largest time.
    function automatic logic [63:0] add_ms(input logic [63:0] t, input logic [21:0] d);
        logic [63:0] d64;
        d64 = {42'd0, d};
        return (t > ~d64) ? TIME_MAX : t + d64;
    endfunction

    // Applies one word to the predicted state and returns the result word it must produce.
    function automatic out_t schedule_step(input in_t w);
        logic [63:0] t;
        logic ok;
        out_t r;
        // A time older than the stored one is replaced by the stored one.
        t = (w.now_ms < last_ms) ? last_ms : w.now_ms;
        r = '0;
        case (w.mode)
            MODE_MOTION:
            begin
                last_ms = t;
                if (w.motion)
                begin
                    // Entering the moving state counts a wake and asks for a report.
                    if (!moving)
                    begin
                        moving = 1'b1;
                        retry_cnt = 2'd0;
                        if (wake_cnt != 32'hFFFF_FFFF)
                            wake_cnt = wake_cnt + 32'd1;
                        pending = 1'b1;
                    end
                    quiet_until_ms = add_ms(t, {3'd0, act_quiet});
                end
                else if (moving && t >= quiet_until_ms)
                begin
                    moving = 1'b0;
                    pending = 1'b1;
                end
            end
            MODE_OUTCOME:
            begin
                last_ms = t;
                pending = 1'b0;
                if (w.sent || moving || retry_cnt >= RETRY_LIMIT)
                begin
                    retry_cnt = 2'd0;
                    next_due_ms = add_ms(t, moving ? {6'd0, act_moving} : act_idle);
                end
                else
                begin
                    // A failed send while idle, below the retry limit, is tried again after the retry gap.
                    retry_cnt = retry_cnt + 2'd1;
                    next_due_ms = add_ms(t, 22'(RETRY_GAP));
                end
            end
            MODE_RECONF:
            begin
                ok = reg_moving >= MOVING_LO && reg_moving <= MOVING_HI
                    && reg_idle >= IDLE_LO && reg_idle <= IDLE_HI
                    && reg_quiet >= QUIET_LO && reg_quiet <= QUIET_HI
                    && reg_idle >= {6'd0, reg_moving};
                // A rejected setting leaves everything alone, the stored time included.
                if (ok)
                begin
                    last_ms = t;
                    act_moving = reg_moving;
                    act_idle = reg_idle;
                    act_quiet = reg_quiet;
                    retry_cnt = 2'd0;
                    if (moving)
                        quiet_until_ms = add_ms(t, {3'd0, act_quiet});
                    pending = 1'b1;
                end
                r.accepted = ok;
            end
            default:
            begin
                // A due query only evaluates the due rule below.
            end
        endcase
        r.due = pending || t >= next_due_ms || (moving && t >= quiet_until_ms);
        r.is_moving = moving;
        r.wakes = wake_cnt;
        r.retries = retry_cnt;
        return r;
    endfunction

    // Prints one line per mismatch, up to a cap that keeps a broken run readable,
    // and counts every one of them.
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic queue_word(input mode_e m, input logic [63:0] t, input logic mo,
                              input logic se);
        in_t w;
        w.mode = m;
        w.now_ms = t;
        w.motion = mo;
        w.sent = se;
        pending_words.push_back(w);
    endtask

    // Queues a run of random words over an advancing time base. Steps are drawn on the
    // scale of the current register settings, so that the quiet deadline, the report
    // deadlines and the retry gap are all crossed. Some words carry an older time, and
    // with wild set some carry an arbitrary 64-bit time.
    task automatic queue_session(input int count, input bit wild);
        logic [63:0] step;
        logic [63:0] t;
        int pick;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(3))
                0: step = 64'($urandom_range(2000));
                1: step = 64'($urandom_range(2 * reg_moving));
                2: step = 64'($urandom_range(2 * reg_quiet));
                default: step = 64'($urandom_range(reg_idle));
            endcase
            clock_ms = (clock_ms > ~step) ? TIME_MAX : clock_ms + step;
            t = clock_ms;
            pick = $urandom_range(99);
            if (wild && pick < 10)
                t = {$urandom, $urandom};
            else if (pick >= 93)
                t = (clock_ms > 64'd20000) ? clock_ms - 64'($urandom_range(20000)) : 64'd0;
            pick = $urandom_range(99);
            if (pick < 40)
                queue_word(MODE_MOTION, t, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (pick < 65)
                queue_word(MODE_OUTCOME, t, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (pick < 85)
                queue_word(MODE_QUERY, t, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                queue_word(MODE_RECONF, t, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    // Writes all three timing registers on consecutive cycles. Only the low bits that
    // each register holds are kept; the rest of the data word is dropped by the block.
    task automatic write_timings(input logic [21:0] mv, input logic [21:0] iv,
                                 input logic [21:0] qv);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MOVING;
        cfg_data <= mv;
        @(negedge clk);
        cfg_index <= CFG_IDLE;
        cfg_data <= iv;
        @(negedge clk);
        cfg_index <= CFG_QUIET;
        cfg_data <= qv;
        @(negedge clk);
        cfg_we <= 1'b0;
        reg_moving = mv[15:0];
        reg_idle = iv;
        reg_quiet = qv[18:0];
    endtask

    // Holds the sender back until every word offered has been taken and every predicted
    // result word has come back. Checked at the rising edge, where neither the word queue
    // nor push can be changing.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || push || predicted_words.size() != 0);
    endtask

    // Sender: a word is offered at the falling edge and held until the block takes it.
    // Between words the sender idles at random except in the calm windows.
    always @(negedge clk)
    begin
        if (rst_n && (!push || word_taken))
        begin
            if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 25))
            begin
                in_data <= pending_words.pop_front();
                push <= 1'b1;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: pop stalls at random about one cycle in four, never in the calm windows.
    always @(negedge clk)
    begin
        pop <= calm || $urandom_range(99) >= 25;
    end

    // Monitor: at each rising edge a word taken by the block is run through the predictor,
    // and a result word taken from the block is compared with the oldest prediction.
    always @(posedge clk)
    begin : monitor
        out_t want;
        word_taken <= push && !full;
        if (rst_n)
        begin
            if (push && !full)
                predicted_words.push_back(schedule_step(in_data));
            if (pop && !empty)
            begin
                if (predicted_words.size() == 0)
                begin
                    report_mismatch("result word arrived with no word outstanding");
                end
                else
                begin
                    want = predicted_words.pop_front();
                    if (out_data !== want)
                        report_mismatch($sformatf(
                            "result %0d got due=%0b mov=%0b wakes=%0d acc=%0b retries=%0d, %s",
                            words_checked, out_data.due, out_data.is_moving, out_data.wakes,
                            out_data.accepted, out_data.retries,
                            $sformatf("want due=%0b mov=%0b wakes=%0d acc=%0b retries=%0d",
                                want.due, want.is_moving, want.wakes, want.accepted,
                                want.retries)));
                    words_checked++;
                end
            end
        end
    end

    // Watchdog: a block that stops taking or returning words ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] mv;
        logic [21:0] iv;
        logic [18:0] qv;

        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_MOVING;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A write to the unused index must not disturb the reset timings, which the
        // reconfigure words of the directed run below rely on.
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SPARE;
        cfg_data <= {CFG_DATA_W{1'b1}};
        @(negedge clk);
        cfg_we <= 1'b0;

        // Directed run with the reset timings (moving 5000, idle 600000, quiet 30000).
        // A report is pending straight out of reset.
        queue_word(MODE_QUERY, 64'd0, 1'b0, 1'b0);
        // A good send schedules the next idle report.
        queue_word(MODE_OUTCOME, 64'd100, 1'b0, 1'b1);
        // Time running backward is held at the stored time.
        queue_word(MODE_QUERY, 64'd50, 1'b1, 1'b1);
        queue_word(MODE_MOTION, 64'd200, 1'b0, 1'b1);
        // First motion: wake counted, report pending, quiet deadline set.
        queue_word(MODE_MOTION, 64'd1000, 1'b1, 1'b0);
        // A failed send while moving still completes the report.
        queue_word(MODE_OUTCOME, 64'd2000, 1'b0, 1'b0);
        queue_word(MODE_MOTION, 64'd10000, 1'b1, 1'b0);
        // Query below the stored time, which is past the moving report deadline.
        queue_word(MODE_QUERY, 64'd7000, 1'b0, 1'b0);
        // One millisecond short of the quiet deadline, then exactly on it.
        queue_word(MODE_MOTION, 64'd39999, 1'b0, 1'b0);
        queue_word(MODE_MOTION, 64'd40000, 1'b0, 1'b1);
        // Idle send failures: two retries, then the third failure gives up.
        queue_word(MODE_OUTCOME, 64'd41000, 1'b0, 1'b0);
        queue_word(MODE_OUTCOME, 64'd46000, 1'b1, 1'b0);
        queue_word(MODE_OUTCOME, 64'd51000, 1'b0, 1'b0);
        queue_word(MODE_OUTCOME, 64'd52000, 1'b0, 1'b0);
        // Reconfigure while idle clears the retry count and raises a report.
        queue_word(MODE_RECONF, 64'd53000, 1'b0, 1'b0);
        queue_word(MODE_MOTION, 64'd54000, 1'b1, 1'b1);
        // Reconfigure while moving pushes the quiet deadline out.
        queue_word(MODE_RECONF, 64'd55000, 1'b1, 1'b0);
        queue_word(MODE_OUTCOME, 64'd56000, 1'b1, 1'b1);
        queue_word(MODE_QUERY, 64'd0, 1'b1, 1'b0);
        // The sender pauses here until every result word has come back.
        wait_drained();
        clock_ms = 64'd60000;

        // Random phases. The first nine use settings at and just past each limit, the
        // later ones random settings; each opens with a reconfigure word so the new
        // setting is tried at once. The last phase runs near the largest time, where
        // every deadline saturates.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: write_timings(22'(MOVING_LO), 22'(IDLE_LO), 22'(QUIET_LO));
                1: write_timings(22'(MOVING_HI), 22'(IDLE_HI), 22'(QUIET_HI));
                2: write_timings(22'(MOVING_HI), 22'(IDLE_LO), 22'(QUIET_HI));
                3: write_timings(22'(MOVING_LO - 1), 22'(IDLE_HI), 22'(QUIET_LO));
                4: write_timings(22'(MOVING_HI + 1), 22'(IDLE_HI), 22'(QUIET_HI));
                5: write_timings(22'(MOVING_LO), 22'(IDLE_LO - 1), 22'(QUIET_LO));
                6: write_timings(22'(MOVING_LO), 22'(IDLE_HI + 1), 22'(QUIET_LO));
                7: write_timings(22'(MOVING_LO), 22'(IDLE_LO), 22'(QUIET_LO - 1));
                8: write_timings(22'(MOVING_LO), 22'(IDLE_LO), 22'(QUIET_HI + 1));
                default:
                begin
                    if ($urandom_range(2) == 0)
                    begin
                        // Raw data words, often out of range once truncated.
                        write_timings(22'($urandom_range(22'h3FFFFF)),
                                      22'($urandom_range(22'h3FFFFF)),
                                      22'($urandom_range(22'h3FFFFF)));
                    end
                    else
                    begin
                        // Valid settings, with junk in the data bits above the moving and quiet registers.
                        mv = 16'($urandom_range(MOVING_LO, MOVING_HI));
                        iv = 22'($urandom_range(IDLE_LO, IDLE_HI));
                        qv = 19'($urandom_range(QUIET_LO, QUIET_HI));
                        write_timings({6'($urandom), mv}, iv, {3'($urandom), qv});
                    end
                end
            endcase
            if (p == PHASES - 1)
                clock_ms = 64'hFFFF_FFFF_FFF0_0000;
            queue_word(MODE_RECONF, clock_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
            queue_session(WORDS_PER_PHASE, p == PHASES - 1);
            if (p == PHASES - 1)
            begin
                // Every mode at the largest time.
                queue_word(MODE_MOTION, TIME_MAX, 1'b1, 1'b0);
                queue_word(MODE_OUTCOME, TIME_MAX, 1'b0, 1'b0);
                queue_word(MODE_RECONF, TIME_MAX, 1'b0, 1'b1);
                queue_word(MODE_MOTION, TIME_MAX, 1'b0, 1'b1);
                queue_word(MODE_QUERY, TIME_MAX, 1'b1, 1'b1);
            end
            wait_drained();
        end

        // Extra cycles before the end, so that a stray result word would still be caught.
        repeat (10) @(negedge clk);
        if (predicted_words.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived",
                                      predicted_words.size()));
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
src/mrs_pkg.sv
src/mrs_front.sv
src/mrs_cmd_fifo.sv
src/mrs_back.sv
src/motion_report_scheduler.sv
test/tb_motion_report_scheduler.sv
